### rtl/kbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kbd_pkg;

    typedef logic [31:0] word_t;
    typedef logic [15:0] half_t;
    typedef logic [7:0]  byte_t;
    typedef logic [2:0]  method_t;
    typedef logic [1:0]  kind_t;

    // Input item kinds
    localparam kind_t KIND_SEED  = 2'd0;
    localparam kind_t KIND_BYTE  = 2'd1;
    localparam kind_t KIND_CHECK = 2'd2;

    // Result kinds
    localparam logic RES_BYTE    = 1'b0;
    localparam logic RES_VERDICT = 1'b1;

    // Number of valid method settings
    localparam method_t METHOD_COUNT = 3'd5;

    // Generator output: next seed and the key half
    typedef struct packed {
        word_t seed;
        half_t key;
    } gen_out_t;

    // Seed mask per method
    function automatic word_t seed_mask(input method_t m);
        word_t r;
        unique case (m)
            3'd0:    r = 32'h4C35_8938;
            3'd1:    r = 32'h91B2_A2D1;
            3'd2:    r = 32'h4A7C_1B87;
            3'd3:    r = 32'hF939_41E6;
            3'd4:    r = 32'hFD09_5E94;
            default: r = 32'h4C35_8938;
        endcase
        return r;
    endfunction

    // Low-half add constant per method
    function automatic half_t low_add(input method_t m);
        half_t r;
        unique case (m)
            3'd0:    r = 16'h62E9;
            3'd1:    r = 16'h7D14;
            3'd2:    r = 16'h1A82;
            3'd3:    r = 16'h02BB;
            3'd4:    r = 16'hE09C;
            default: r = 16'h62E9;
        endcase
        return r;
    endfunction

    // High-half add constant per method
    function automatic half_t high_add(input method_t m);
        half_t r;
        unique case (m)
            3'd0:    r = 16'h3619;
            3'd1:    r = 16'hA26B;
            3'd2:    r = 16'hF03C;
            3'd3:    r = 16'h7B12;
            3'd4:    r = 16'h4E8F;
            default: r = 16'h3619;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/kbd_keygen.sv
`timescale 1ns / 1ps
`default_nettype none

// One step of the keystream generator: shift-with-fill on both halves,
// then 16-bit adds with the method constants.
module kbd_keygen (
    input  wire kbd_pkg::word_t   seed,
    input  wire kbd_pkg::method_t method_sel,
    output kbd_pkg::gen_out_t     gen
);
    import kbd_pkg::*;

    logic  c_bit;
    logic  d_bit;
    half_t hi_half;
    half_t nh_fill;
    half_t nl_fill;
    half_t nh;
    half_t nl;

    assign hi_half = seed[23:8];
    assign c_bit   = seed[31];
    assign d_bit   = seed[23];

    // Fills: seed[23:8]<<1 (ones if bit 31), seed[6:0]<<9 (ones if bit 23)
    assign nh_fill = c_bit ? 16'hFFFF : {hi_half[14:0], 1'b0};
    assign nl_fill = d_bit ? 16'hFFFF : {seed[6:0], 9'b0};

    assign nl = nl_fill + seed[15:0] + low_add(method_sel);
    assign nh = nh_fill + seed[31:16] + high_add(method_sel)
                - {15'b0, c_bit} - {15'b0, d_bit};

    // Negative low half borrows one from the high half of the new seed
    assign gen.seed = {nh - {15'b0, nl[15]}, nl};
    assign gen.key  = nh;

endmodule

`default_nettype wire

### rtl/keystream_byte_descrambler_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Keystream byte descrambler.
// Input channel (in_valid / in_stall): kind and value. A seed word restarts
// the generator and clears both checksums; a payload byte returns one decoded
// byte; a checksum word returns one pass/fail verdict. Kind 3 is dropped.
// Output channel (out_valid / out_stall): result_kind, plain_byte, check_ok.
// Config channel (cfg_valid / cfg_ready): 3-bit method, 0..4; other values
// are ignored. Write only while the block is idle. cfg_ready is always high.
// Throughput: one beat per cycle while out_stall is low. A beat passes
// through the input register, then the generator and checksum logic, into
// the result register, which drives the output ports.
// When the receiver stalls, the result register holds; one further input
// beat waits in the input register and in_stall rises once that beat
// needs the result register. Seed and dropped beats never stall.
// Reset (rst_n low, async) clears method, generator seed, key byte, byte
// parity, checksums and both valid flags.
module keystream_byte_descrambler_core (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire kbd_pkg::method_t   method,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire kbd_pkg::kind_t     kind,
    input  wire kbd_pkg::word_t     value,
    output logic                    out_valid,
    input  wire                     out_stall,
    output logic                    result_kind,
    output kbd_pkg::byte_t          plain_byte,
    output logic                    check_ok
);
    import kbd_pkg::*;

    // Configuration
    method_t  method_reg;

    // Input register
    logic     in_vld_reg;
    kind_t    in_kind_reg;
    word_t    in_value_reg;

    // Block state
    word_t    gen_seed_reg,  gen_seed_next;
    logic     odd_reg,       odd_next;
    byte_t    key_reg,       key_next;
    half_t    sum_plain_reg, sum_plain_next;
    half_t    sum_rot_reg,   sum_rot_next;

    // Result register
    logic     out_vld_reg,   out_vld_next;
    logic     out_kind_reg,  out_kind_next;
    byte_t    out_byte_reg,  out_byte_next;
    logic     out_ok_reg,    out_ok_next;

    // Stage control
    logic     produces;
    logic     out_free;
    logic     advance;
    logic     in_accept;

    // Datapath
    gen_out_t gen;
    byte_t    dec_byte;
    half_t    rot_ext;
    half_t    chk1;
    half_t    chk2;

    kbd_keygen u_keygen (
        .seed       (gen_seed_reg),
        .method_sel (method_reg),
        .gen        (gen)
    );

    // Handshakes
    assign produces  = (in_kind_reg == KIND_BYTE) || (in_kind_reg == KIND_CHECK);
    assign out_free  = !out_vld_reg || !out_stall;
    assign advance   = in_vld_reg && (!produces || out_free);
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Decoded byte: even positions XOR a fresh key, odd positions subtract it
    assign dec_byte = odd_reg ? (in_value_reg[7:0] - key_reg)
                              : (in_value_reg[7:0] ^ gen.key[7:0]);

    // Rotating sum: top nibble folds back sign-extended
    assign rot_ext = {{12{sum_rot_reg[15]}}, sum_rot_reg[15:12]};

    // Unmasked checksums
    assign chk1 = in_value_reg[31:16] ^ gen.key;
    assign chk2 = in_value_reg[15:0] - gen.key;

    // Processing stage: state update and result
    always_comb
    begin
        gen_seed_next  = gen_seed_reg;
        odd_next       = odd_reg;
        key_next       = key_reg;
        sum_plain_next = sum_plain_reg;
        sum_rot_next   = sum_rot_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_ok_next    = out_ok_reg;
        if (advance)
        begin
            unique case (in_kind_reg)
                KIND_SEED:
                begin
                    gen_seed_next  = in_value_reg ^ seed_mask(method_reg);
                    odd_next       = 1'b0;
                    key_next       = '0;
                    sum_plain_next = '0;
                    sum_rot_next   = '0;
                end
                KIND_BYTE:
                begin
                    if (!odd_reg)
                    begin
                        gen_seed_next = gen.seed;
                        key_next      = gen.key[7:0];
                    end
                    odd_next       = !odd_reg;
                    sum_plain_next = sum_plain_reg + {8'h00, dec_byte};
                    sum_rot_next   = {sum_rot_reg[11:0], 4'h0} + rot_ext
                                     + {8'h00, dec_byte};
                    out_kind_next  = RES_BYTE;
                    out_byte_next  = dec_byte;
                    out_ok_next    = 1'b0;
                end
                KIND_CHECK:
                begin
                    gen_seed_next = gen.seed;
                    out_kind_next = RES_VERDICT;
                    out_byte_next = '0;
                    out_ok_next   = (chk1 == sum_plain_reg) && (chk2 == sum_rot_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result valid
    always_comb
    begin
        if (advance && produces)
            out_vld_next = 1'b1;
        else if (!out_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg    <= '0;
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            gen_seed_reg  <= '0;
            odd_reg       <= 1'b0;
            key_reg       <= '0;
            sum_plain_reg <= '0;
            sum_rot_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && (method < METHOD_COUNT))
                method_reg <= method;
            if (in_accept)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;
            out_vld_reg   <= out_vld_next;
            gen_seed_reg  <= gen_seed_next;
            odd_reg       <= odd_next;
            key_reg       <= key_next;
            sum_plain_reg <= sum_plain_next;
            sum_rot_reg   <= sum_rot_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_kind_reg  <= kind;
            in_value_reg <= value;
        end
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_ok_reg   <= out_ok_next;
    end

    assign out_valid   = out_vld_reg;
    assign result_kind = out_kind_reg;
    assign plain_byte  = out_byte_reg;
    assign check_ok    = out_ok_reg;

endmodule

`default_nettype wire

### rtl/kbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the descrambler
module kbd_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_stall,
    input wire       out_valid,
    input wire       out_stall,
    input wire       result_kind,
    input wire [7:0] plain_byte,
    input wire       check_ok
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable({result_kind, plain_byte, check_ok}))
        else $error("result payload changed while stalled");

    // Input only backs up behind a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // Verdict beats carry no byte
    a_verdict_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> plain_byte == 8'h00)
        else $error("verdict beat with nonzero byte");

    // Byte beats carry no pass flag
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_kind |-> !check_ok)
        else $error("byte beat with check flag set");

endmodule

bind keystream_byte_descrambler_core kbd_checker u_kbd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .plain_byte  (plain_byte),
    .check_ok    (check_ok)
);

`default_nettype wire
